// ===== rtl/ifc_pkg.sv =====
// Shared types and codes for the IP flow count table.
`timescale 1ns / 1ps
`default_nettype none

package ifc_pkg;

  // Action codes carried on the input tuser
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_NEW        = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ
  } back_state_t;

  // Flow key as stored in the key memory
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
  } flow_key_t;

  localparam int KEY_W = $bits(flow_key_t);

  // Classified command handed from front to back
  typedef struct packed {
    logic      is_read;
    flow_key_t key;
    logic [5:0] rd_index;
  } flow_cmd_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [5:0]  index;
    flow_key_t   key;
    logic [31:0] count;
  } flow_res_t;

endpackage

`default_nettype wire

// ===== rtl/ifc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ifc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ifc_front.sv =====
// Input side: accepts transfers, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module ifc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [79:0]       in_tdata,  // src, dst, proto, read_index, pad
  input  wire logic [0:0]        in_tuser,  // action
  output logic                   cmd_valid,
  output ifc_pkg::flow_cmd_t     cmd,
  input  wire logic              cmd_pop
);

  import ifc_pkg::*;

  flow_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  flow_cmd_t  in_cmd;
  logic       push;

  // Classify the incoming transfer
  always_comb begin
    in_cmd.is_read   = (in_tuser[0] == ACT_READ);
    in_cmd.key.src   = in_tdata[31:0];
    in_cmd.key.dst   = in_tdata[63:32];
    in_cmd.key.proto = in_tdata[71:64];
    in_cmd.rd_index  = in_tdata[77:72];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Two-entry queue bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ifc_back.sv =====
// Execution side: table scan, count update, append and read, with result register.
`timescale 1ns / 1ps
`default_nettype none

module ifc_back #(
  parameter int FLOW_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire ifc_pkg::flow_cmd_t cmd,
  output logic                   cmd_pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output ifc_pkg::flow_res_t     res
);

  import ifc_pkg::*;

  localparam int IW = $clog2(FLOW_ENTRIES);
  localparam int CW = IW + 1;
  localparam int XW = IW + 7;

  back_state_t   state_r, state_nxt;
  flow_cmd_t     cur_r, cur_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          out_vld_r, out_vld_nxt;
  flow_res_t     res_r, res_nxt;

  // Memory ports
  logic [IW-1:0] raddr, waddr;
  logic          key_we, cnt_we;
  flow_key_t     wkey, rkey;
  logic [31:0]   wcnt, rcnt, rcnt_inc;
  logic [KEY_W-1:0] rkey_bits;

  // Helpers
  logic          slot_free, rd_hit, last_entry, miss_en;
  flow_key_t     miss_key;
  logic [XW-1:0] rd_ext;

  function automatic logic [5:0] idx6(input logic [IW-1:0] i);
    logic [XW-1:0] w;
    w = XW'(i);
    return w[5:0];
  endfunction

  ifc_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey_bits)
  );

  ifc_ram #(.WIDTH(32), .DEPTH(FLOW_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (wcnt),
    .raddr (raddr),
    .rdata (rcnt)
  );

  assign rkey       = rkey_bits;
  assign rcnt_inc   = (rcnt == 32'hFFFF_FFFF) ? rcnt : rcnt + 32'd1;
  assign slot_free  = !out_vld_r || res_ready;
  assign rd_ext     = XW'(cmd.rd_index);
  assign rd_hit     = (rd_ext < XW'(used_r)) && (rd_ext < XW'(FLOW_ENTRIES));
  assign last_entry = ((CW'(cmp_idx_r) + CW'(1)) == used_r);

  // Sequencer: next state, memory control and result load
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    ptr_nxt     = ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    used_nxt    = used_r;
    out_vld_nxt = out_vld_r && !res_ready;
    res_nxt     = res_r;
    raddr       = ptr_r;
    waddr       = cmp_idx_r;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    wkey        = cur_r.key;
    wcnt        = rcnt_inc;
    cmd_pop     = 1'b0;
    miss_en     = 1'b0;
    miss_key    = cur_r.key;

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          if (cmd.is_read) begin
            if (rd_hit) begin
              raddr     = rd_ext[IW-1:0];
              state_nxt = BK_READ;
            end else begin
              out_vld_nxt    = 1'b1;
              res_nxt.status = ST_READ_EMPTY;
              res_nxt.index  = cmd.rd_index;
              res_nxt.key    = '0;
              res_nxt.count  = '0;
            end
          end else if (used_r == '0) begin
            miss_en  = 1'b1;
            miss_key = cmd.key;
          end else begin
            raddr       = '0;
            ptr_nxt     = IW'(1);
            cmp_idx_nxt = '0;
            state_nxt   = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        // Read data belongs to cmp_idx_r; keep streaming the next address
        raddr       = ptr_r;
        ptr_nxt     = ptr_r + IW'(1);
        cmp_idx_nxt = ptr_r;
        if (rkey == cur_r.key) begin
          cnt_we         = 1'b1;
          waddr          = cmp_idx_r;
          wcnt           = rcnt_inc;
          out_vld_nxt    = 1'b1;
          res_nxt.status = ST_HIT;
          res_nxt.index  = idx6(cmp_idx_r);
          res_nxt.key    = cur_r.key;
          res_nxt.count  = rcnt_inc;
          state_nxt      = BK_IDLE;
        end else if (last_entry) begin
          miss_en   = 1'b1;
          miss_key  = cur_r.key;
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: begin
        out_vld_nxt    = 1'b1;
        res_nxt.status = ST_READ_OK;
        res_nxt.index  = cur_r.rd_index;
        res_nxt.key    = rkey;
        res_nxt.count  = rcnt;
        state_nxt      = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Key not found: append, or drop when the table is full
    if (miss_en) begin
      out_vld_nxt = 1'b1;
      if (used_r == CW'(FLOW_ENTRIES)) begin
        res_nxt.status = ST_FULL;
        res_nxt.index  = '0;
        res_nxt.key    = '0;
        res_nxt.count  = '0;
      end else begin
        key_we         = 1'b1;
        cnt_we         = 1'b1;
        waddr          = used_r[IW-1:0];
        wkey           = miss_key;
        wcnt           = 32'd1;
        used_nxt       = used_r + CW'(1);
        res_nxt.status = ST_NEW;
        res_nxt.index  = idx6(used_r[IW-1:0]);
        res_nxt.key    = miss_key;
        res_nxt.count  = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    ptr_r     <= ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== rtl/ip_flow_count_table.sv =====
// Top level of the exact-match IP flow count table.
// A read of an unused index or a record into an empty table is answered at the queue pop;
// a read waits for the memory read; a record scans up to a hit or the last used entry.
// Throughput: one item at a time in the back end; the linear key scan through the
// key memory (one entry per cycle) sets the record cost. The input is queued and the
// output registered; transfers queue while a result waits, but no new command starts.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ip_flow_count_table #(
  parameter int FLOW_ENTRIES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // source_address, destination_address,
                                        // protocol_number, read_index, pad
  input  wire logic [0:0]   in_tuser,   // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // entry_index, entry_source, entry_destination,
                                        // entry_protocol, entry_count, pad
  output logic [2:0]        out_tuser   // status
);

  import ifc_pkg::*;

  logic      cmd_valid, cmd_pop;
  flow_cmd_t cmd;
  flow_res_t res;

  ifc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ifc_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result transfer
  assign out_tuser = res.status;
  assign out_tdata = {2'b00, res.count, res.key.proto, res.key.dst, res.key.src, res.index};

endmodule

`default_nettype wire
